// ===== rtl/core/plc_pkg.sv =====
// Package with the shared types and codes of the ping liveness checker.
`timescale 1ns / 1ps

package plc_pkg;

    // Command codes of an input item.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_REPLY = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // Event codes of a result item.
    localparam logic [1:0] EV_SEND       = 2'd0;
    localparam logic [1:0] EV_PASS       = 2'd1;
    localparam logic [1:0] EV_UNPINGABLE = 2'd2;

    // Saturation limit of the per-check counters.
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // One input item.
    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot;
        logic [31:0] now_seconds;
        logic [15:0] echo_id;
        logic [7:0]  send_limit;
        logic [7:0]  reply_minimum;
    } plc_in_t;

    // One result item.
    typedef struct packed {
        logic [3:0]  out_slot;
        logic [1:0]  event_res;
        logic [15:0] sequence_res;
        logic [15:0] ident;
    } plc_out_t;

    // One entry of the check table memory.
    typedef struct packed {
        logic [15:0] ident;
        logic [7:0]  sent_count;
        logic [7:0]  reply_count;
        logic [31:0] last_send_time;
        logic [7:0]  attempt_limit;
        logic [7:0]  needed_replies;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Decision for a start or service tick, from the evaluator to the controller.
    typedef struct packed {
        logic        emit;
        logic        write;
        logic        keep_active;
        logic [15:0] gen_next;
        entry_t      wr_entry;
        plc_out_t    result;
    } decision_t;

endpackage

// ===== rtl/core/plc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module plc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/plc_eval.sv =====
// Evaluator that decides the outcome of a start command or a service tick.
`timescale 1ns / 1ps

module plc_eval
    import plc_pkg::*;
(
    input  plc_in_t     item,
    input  entry_t      entry,
    input  logic [7:0]  reply_wait,
    input  logic [15:0] gen,
    output decision_t   dec
);

    logic [15:0] ident_sum;
    logic [15:0] ident_new;
    logic [31:0] elapsed;
    logic [7:0]  sent_new;

    // Next odd identifier: add two, then one more if the sum is even.
    assign ident_sum = gen + 16'd2;
    assign ident_new = ident_sum[0] ? ident_sum : ident_sum + 16'd1;

    // Time since the last send, modulo 2^32.
    assign elapsed = item.now_seconds - entry.last_send_time;

    // Sent count for a resend, saturating.
    assign sent_new = (entry.sent_count != COUNT_MAX) ? entry.sent_count + 8'd1
                                                      : entry.sent_count;

    always_comb
    begin
        dec                     = '0;
        dec.gen_next            = gen;
        dec.wr_entry            = entry;
        dec.result.out_slot     = item.slot;
        dec.result.ident        = entry.ident;
        dec.result.event_res    = EV_SEND;
        dec.result.sequence_res = 16'd0;
        if (item.command == CMD_START)
        begin
            // Fresh check: first request carries sequence number one.
            dec.emit                    = 1'b1;
            dec.write                   = 1'b1;
            dec.keep_active             = 1'b1;
            dec.gen_next                = ident_new;
            dec.wr_entry.ident          = ident_new;
            dec.wr_entry.sent_count     = 8'd1;
            dec.wr_entry.reply_count    = 8'd0;
            dec.wr_entry.last_send_time = item.now_seconds;
            dec.wr_entry.attempt_limit  = item.send_limit;
            dec.wr_entry.needed_replies = item.reply_minimum;
            dec.result.ident            = ident_new;
            dec.result.sequence_res     = 16'd1;
        end
        else if (elapsed > {24'd0, reply_wait})
        begin
            dec.emit = 1'b1;
            if (entry.sent_count >= entry.attempt_limit)
            begin
                // Out of attempts.
                dec.result.event_res = EV_UNPINGABLE;
            end
            else if (entry.reply_count < entry.needed_replies)
            begin
                // Not enough replies yet: send another request.
                dec.write                   = 1'b1;
                dec.keep_active             = 1'b1;
                dec.wr_entry.sent_count     = sent_new;
                dec.wr_entry.last_send_time = item.now_seconds;
                dec.result.sequence_res     = {8'd0, sent_new};
            end
            else
            begin
                dec.result.event_res = EV_PASS;
            end
        end
        else
        begin
            // Still inside the reply wait: nothing to do.
            dec.keep_active = 1'b1;
        end
    end

endmodule

// ===== rtl/core/ping_liveness_checker_core.sv =====
// Top level of the ping liveness checker: controller, check table and result register.
`timescale 1ns / 1ps
//
// Commands arrive on the item channel (valid/ready) and results leave on the
// result channel (valid/ready); each transfer moves one packed struct.
// The check table lives in a RAM with a registered read port; the
// active flags are flip-flops cleared by reset.
// A start or service tick reads the table entry as the item is taken, then
// decides, writes back and loads the result register in ST_EXEC. A stop or
// an ignored command is handled in the idle state. An echo reply walks the
// table one slot per cycle through the single read port of the RAM.
// One item is in work at a time; the next item is taken as soon as the
// controller is idle, even while a result still waits in the output register.
// If the receiver stalls and the result register is still full, a start or
// tick that produces a result holds in ST_EXEC until the register
// frees up.
// Reset clears all active flags and the identifier generator and sets the
// reply wait to one second; table entries are not cleared, since a start
// writes an entry before its contents are ever used.
// The reply wait register is written on any cycle with wr_en high.

module ping_liveness_checker_core
    import plc_pkg::*;
#(
    parameter int CHECK_SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  plc_in_t    item,
    output logic       result_valid,
    input  logic       result_ready,
    output plc_out_t   result,
    input  logic       wr_en,
    input  logic [7:0] wr_data
);

    localparam int IDX_W = (CHECK_SLOTS > 1) ? $clog2(CHECK_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHECK_SLOTS - 1);
    localparam logic [8:0] SLOTS_LIM = 9'(CHECK_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    state_t                 state_reg, state_next;
    plc_in_t                item_reg, item_next;
    plc_out_t               result_reg, result_next;
    logic                   result_valid_reg, result_valid_next;
    logic [CHECK_SLOTS-1:0] active_reg, active_next;
    logic [15:0]            gen_reg, gen_next;
    logic [7:0]             wait_reg, wait_next;
    logic [IDX_W-1:0]       chk_reg, chk_next;

    logic [IDX_W-1:0]       in_idx;
    logic [IDX_W-1:0]       item_idx;
    logic                   in_range;
    logic                   can_emit;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [IDX_W-1:0]       ram_raddr;
    entry_t                 ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;
    entry_t                 rd_entry;
    decision_t              dec;

    assign in_idx       = IDX_W'(item.slot);
    assign item_idx     = IDX_W'(item_reg.slot);
    assign in_range     = ({5'd0, item.slot} < SLOTS_LIM);
    assign can_emit     = !result_valid_reg || result_ready;
    assign rd_entry     = entry_t'(ram_rdata);
    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Check table memory.
    plc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CHECK_SLOTS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Outcome of a start or service tick.
    plc_eval u_eval (
        .item      (item_reg),
        .entry     (rd_entry),
        .reply_wait(wait_reg),
        .gen       (gen_reg),
        .dec       (dec)
    );

    // Controller next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        active_next       = active_reg;
        gen_next          = gen_reg;
        wait_next         = wr_en ? wr_data : wait_reg;
        chk_next          = chk_reg;
        ram_we            = 1'b0;
        ram_waddr         = item_idx;
        ram_wdata         = dec.wr_entry;
        ram_raddr         = item_idx;
        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = in_idx;
                if (item_valid)
                begin
                    item_next = item;
                    if (item.command == CMD_REPLY)
                    begin
                        // Walk starts at slot zero, read issued this cycle.
                        ram_raddr  = '0;
                        chk_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else if (in_range)
                    begin
                        if (item.command == CMD_STOP)
                        begin
                            active_next[in_idx] = 1'b0;
                        end
                        else if (item.command == CMD_START || active_reg[in_idx])
                        begin
                            state_next = ST_EXEC;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // Read the following slot while checking the current one.
                ram_raddr = (chk_reg == LAST_IDX) ? '0 : chk_reg + IDX_W'(1);
                ram_waddr = chk_reg;
                ram_wdata = rd_entry;
                ram_wdata.reply_count = rd_entry.reply_count + 8'd1;
                if (active_reg[chk_reg] && rd_entry.ident == item_reg.echo_id
                    && rd_entry.reply_count != COUNT_MAX)
                begin
                    ram_we = 1'b1;
                end
                chk_next = ram_raddr;
                if (chk_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                if (!dec.emit)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_emit)
                begin
                    ram_we                = dec.write;
                    active_next[item_idx] = dec.keep_active;
                    gen_next              = dec.gen_next;
                    result_next           = dec.result;
                    result_valid_next     = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            item_reg         <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
            active_reg       <= '0;
            gen_reg          <= 16'd0;
            wait_reg         <= 8'd1;
            chk_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            item_reg         <= item_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
            active_reg       <= active_next;
            gen_reg          <= gen_next;
            wait_reg         <= wait_next;
            chk_reg          <= chk_next;
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the ping liveness checker core.
`timescale 1ns / 1ps

module testbench
    import plc_pkg::*;
();

    localparam int SLOTS = 16;
    localparam int SETTLE_CYCLES = SLOTS + 8;
    localparam int REPORT_LIMIT = 10;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    plc_in_t    item = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    plc_out_t   result;
    logic       wr_en = 1'b0;
    logic [7:0] wr_data = 8'd0;

    // Commands waiting to be sent and events the block still owes.
    plc_in_t  cmd_queue [$];
    plc_out_t owed_events [$];
    plc_out_t predicted;
    plc_out_t owed_head;

    // Shadow of the check table and the reply wait register.
    bit          tbl_active [SLOTS] = '{default: 1'b0};
    logic [15:0] tbl_ident [SLOTS] = '{default: '0};
    logic [7:0]  tbl_sent [SLOTS] = '{default: '0};
    logic [7:0]  tbl_replies [SLOTS] = '{default: '0};
    logic [31:0] tbl_sent_at [SLOTS] = '{default: '0};
    logic [7:0]  tbl_limit [SLOTS] = '{default: '0};
    logic [7:0]  tbl_needed [SLOTS] = '{default: '0};
    logic [15:0] ident_seed = 16'd0;
    logic [7:0]  wait_cfg = 8'd1;

    // Stimulus bookkeeping: a virtual wall clock and the identifier each slot got last.
    logic [31:0] clock_s = 32'd1000;
    logic [15:0] stim_gen = 16'd0;
    logic [15:0] slot_echo_id [SLOTS] = '{default: '0};

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned failures = 0;

    ping_liveness_checker_core #(
        .CHECK_SLOTS (SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .wr_en        (wr_en),
        .wr_data      (wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the shadow table by one command and work out the event it causes, if any.
    function automatic bit apply_command(input plc_in_t it, output plc_out_t res);
        logic [3:0]  s;
        logic [31:0] elapsed;
        s = it.slot;
        res = '0;
        res.out_slot = s;
        if (it.command == CMD_REPLY)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tbl_active[i] && tbl_ident[i] == it.echo_id && tbl_replies[i] != COUNT_MAX)
                    tbl_replies[i] = tbl_replies[i] + 8'd1;
            end
            return 1'b0;
        end
        if (int'(s) >= SLOTS)
            return 1'b0;
        if (it.command == CMD_START)
        begin
            // Identifiers step by two and are forced odd.
            ident_seed = ident_seed + 16'd2;
            if (!ident_seed[0])
                ident_seed = ident_seed + 16'd1;
            tbl_active[s] = 1'b1;
            tbl_ident[s] = ident_seed;
            tbl_replies[s] = 8'd0;
            tbl_sent[s] = 8'd1;
            tbl_limit[s] = it.send_limit;
            tbl_needed[s] = it.reply_minimum;
            tbl_sent_at[s] = it.now_seconds;
            res.event_res = EV_SEND;
            res.sequence_res = 16'd1;
            res.ident = ident_seed;
            return 1'b1;
        end
        if (it.command == CMD_STOP)
        begin
            tbl_active[s] = 1'b0;
            return 1'b0;
        end
        // Service tick: judge the check only once the wait has run out.
        if (!tbl_active[s])
            return 1'b0;
        elapsed = it.now_seconds - tbl_sent_at[s];
        if (elapsed <= {24'd0, wait_cfg})
            return 1'b0;
        res.ident = tbl_ident[s];
        if (tbl_sent[s] >= tbl_limit[s])
        begin
            tbl_active[s] = 1'b0;
            res.event_res = EV_UNPINGABLE;
            return 1'b1;
        end
        if (tbl_replies[s] < tbl_needed[s])
        begin
            if (tbl_sent[s] != COUNT_MAX)
                tbl_sent[s] = tbl_sent[s] + 8'd1;
            tbl_sent_at[s] = it.now_seconds;
            res.event_res = EV_SEND;
            res.sequence_res = {8'd0, tbl_sent[s]};
            return 1'b1;
        end
        tbl_active[s] = 1'b0;
        res.event_res = EV_PASS;
        return 1'b1;
    endfunction

    function automatic void note_failure(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0h, actual %0h", what, want, got);
    endfunction

    // Driver: present queued commands, predicting each one as its transfer completes.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                if (apply_command(item, predicted))
                    owed_events.push_back(predicted);
            end
            if (!item_valid || item_ready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item <= cmd_queue.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every result transfer with the oldest owed event.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (owed_events.size() == 0)
                begin
                    note_failure("unexpected result", 32'd0, 32'(result));
                end
                else
                begin
                    owed_head = owed_events.pop_front();
                    if (result.out_slot != owed_head.out_slot)
                        note_failure("out_slot", 32'(owed_head.out_slot), 32'(result.out_slot));
                    if (result.event_res != owed_head.event_res)
                        note_failure("event_res", 32'(owed_head.event_res),
                                     32'(result.event_res));
                    if (result.sequence_res != owed_head.sequence_res)
                        note_failure("sequence_res", 32'(owed_head.sequence_res),
                                     32'(result.sequence_res));
                    if (result.ident != owed_head.ident)
                        note_failure("ident", 32'(owed_head.ident), 32'(result.ident));
                end
            end
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Queue one command; a start also records the identifier it will hand out.
    task automatic push_cmd(input logic [1:0] cmd, input logic [3:0] s, input logic [31:0] now,
                            input logic [15:0] eid, input logic [7:0] lim,
                            input logic [7:0] minr);
        plc_in_t it;
        it.command = cmd;
        it.slot = s;
        it.now_seconds = now;
        it.echo_id = eid;
        it.send_limit = lim;
        it.reply_minimum = minr;
        if (cmd == CMD_START)
        begin
            stim_gen = stim_gen + 16'd2;
            if (!stim_gen[0])
                stim_gen = stim_gen + 16'd1;
            slot_echo_id[s] = stim_gen;
        end
        cmd_queue.push_back(it);
    endtask

    // Mostly well-formed traffic on a few busy slots, with some raw noise mixed in.
    task automatic random_command();
        int unsigned pick;
        int unsigned step;
        logic [3:0]  s;
        logic [7:0]  lim;
        logic [7:0]  minr;
        pick = $urandom_range(99);
        s = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        if (pick < 8)
        begin
            push_cmd(2'($urandom), 4'($urandom), $urandom(), 16'($urandom), 8'($urandom),
                     8'($urandom));
        end
        else if (pick < 28)
        begin
            lim = ($urandom_range(99) < 85) ? 8'($urandom_range(5)) : 8'($urandom);
            minr = ($urandom_range(99) < 85) ? 8'($urandom_range(3)) : 8'($urandom);
            push_cmd(CMD_START, s, clock_s, 16'($urandom), lim, minr);
        end
        else if (pick < 60)
        begin
            // Move the wall clock: small steps, steps around the wait, jumps and rewinds.
            step = $urandom_range(9);
            if (step < 4)
                clock_s = clock_s + $urandom_range(2);
            else if (step < 8)
                clock_s = clock_s + {24'd0, wait_cfg} + $urandom_range(2);
            else if (step == 8)
                clock_s = clock_s + $urandom();
            else
                clock_s = clock_s - $urandom_range(1, 1000);
            push_cmd(CMD_TICK, s, clock_s, 16'($urandom), 8'($urandom), 8'($urandom));
        end
        else if (pick < 90)
        begin
            push_cmd(CMD_REPLY, 4'($urandom), $urandom(), slot_echo_id[s], 8'($urandom),
                     8'($urandom));
        end
        else
        begin
            push_cmd(CMD_STOP, s, $urandom(), 16'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // More replies than the counter can hold, then a tick that should pass the check.
    task automatic flood_replies();
        logic [3:0] s;
        int unsigned n;
        s = 4'($urandom);
        n = 256 + $urandom_range(4);
        push_cmd(CMD_START, s, clock_s, 16'd0, 8'd255, 8'd255);
        for (int i = 0; i < n; i++)
            push_cmd(CMD_REPLY, 4'($urandom), $urandom(), slot_echo_id[s], 8'd0, 8'd0);
        clock_s = clock_s + {24'd0, wait_cfg} + 32'd1;
        push_cmd(CMD_TICK, s, clock_s, 16'd0, 8'd0, 8'd0);
    endtask

    // Resend until the send limit of 255 is used up, then once more for the verdict.
    task automatic exhaust_sends();
        logic [3:0] s;
        s = 4'($urandom);
        push_cmd(CMD_START, s, clock_s, 16'd0, 8'd255, 8'd255);
        for (int i = 0; i < 255; i++)
        begin
            clock_s = clock_s + {24'd0, wait_cfg} + 32'd1 + $urandom_range(3);
            push_cmd(CMD_TICK, s, clock_s, 16'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // Wait until every command is sent and every owed event has come back.
    task automatic settle();
        while (cmd_queue.size() != 0 || item_valid || owed_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_wait(input logic [7:0] value);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_data <= value;
        wait_cfg = value;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // The reply wait changes only once the block has drained.
    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input logic [7:0] wait_value, input int unsigned count);
        settle();
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        write_wait(wait_value);
        for (int i = 0; i < count; i++)
            random_command();
        settle();
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases with the reset wait of one second.
        push_cmd(CMD_TICK, 4'd0, 32'd5, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_STOP, 4'd5, 32'd0, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_START, 4'd0, 32'hFFFF_FFFF, 16'd0, 8'd2, 8'd1);
        push_cmd(CMD_TICK, 4'd0, 32'd0, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_TICK, 4'd0, 32'd1, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_REPLY, 4'd0, 32'd0, slot_echo_id[0], 8'd0, 8'd0);
        push_cmd(CMD_TICK, 4'd0, 32'd4, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_START, 4'd15, 32'd100, 16'hFFFF, 8'd3, 8'd0);
        push_cmd(CMD_TICK, 4'd15, 32'd102, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_START, 4'd7, 32'd0, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_TICK, 4'd7, 32'd2, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_START, 4'd3, 32'd50, 16'd0, 8'd255, 8'd255);
        push_cmd(CMD_REPLY, 4'd0, 32'd0, slot_echo_id[3], 8'd0, 8'd0);
        push_cmd(CMD_START, 4'd3, 32'd60, 16'd0, 8'd4, 8'd2);
        push_cmd(CMD_REPLY, 4'd0, 32'd0, slot_echo_id[3] - 16'd2, 8'd0, 8'd0);
        push_cmd(CMD_REPLY, 4'd0, 32'd0, slot_echo_id[3], 8'd0, 8'd0);
        push_cmd(CMD_TICK, 4'd3, 32'd60, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_TICK, 4'd3, 32'd62, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_START, 4'd4, 32'd10, 16'd0, 8'd5, 8'd1);
        push_cmd(CMD_STOP, 4'd4, 32'd11, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_TICK, 4'd4, 32'd100, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_START, 4'd9, 32'h8000_0000, 16'd0, 8'd255, 8'd255);
        push_cmd(CMD_TICK, 4'd9, 32'h7FFF_FFFF, 16'd0, 8'd0, 8'd0);
        push_cmd(CMD_REPLY, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF);
        push_cmd(CMD_REPLY, 4'd0, 32'd0, 16'd0, 8'd0, 8'd0);
        settle();

        flood_replies();
        run_phase(66, 0, 8'd0, 130);
        exhaust_sends();
        run_phase(0, 66, 8'd255, 130);
        flood_replies();
        run_phase(13, 13, 8'd3, 130);
        run_phase(0, 0, 8'd1, 130);
        run_phase(66, 66, 8'($urandom_range(2, 20)), 130);

        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
